### src/catan_pkg.sv
// Package for the CORDIC arctangent unit: widths, pipeline depth and the
// per-step angle constants. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package catan_pkg;

   localparam int ITERATIONS    = 16;
   localparam int FRACTION_BITS = 16;

   // The angle table holds 24 entries, so later steps are never built.
   localparam int TABLE_LEN  = 24;
   localparam int TABLE_FRAC = 30;
   localparam int STAGES     = (ITERATIONS < TABLE_LEN) ? ITERATIONS : TABLE_LEN;

   localparam int IN_WIDTH    = 32;
   localparam int OUT_WIDTH   = 18;
   // Four guard bits cover the CORDIC gain on a full-scale tangent.
   localparam int XY_WIDTH    = IN_WIDTH + 4;
   localparam int ANGLE_WIDTH = (FRACTION_BITS + 3 > OUT_WIDTH + 1) ?
                                (FRACTION_BITS + 3) : (OUT_WIDTH + 1);

   localparam int OUT_MAX = (1 << (OUT_WIDTH - 1)) - 1;
   localparam int OUT_MIN = -(1 << (OUT_WIDTH - 1));

   localparam int TABLE_DROP = TABLE_FRAC - FRACTION_BITS;

   typedef logic signed [XY_WIDTH-1:0]    xy_type;
   typedef logic signed [ANGLE_WIDTH-1:0] angle_type;
   typedef logic signed [OUT_WIDTH-1:0]   result_type;

   // atan(2^-i) with 30 fraction bits.
   localparam logic [31:0] ATAN_TABLE [0:TABLE_LEN-1] = '{
      32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159,
      32'd67021687,  32'd33543516,  32'd16775851,  32'd8388437,
      32'd4194283,   32'd2097149,   32'd1048576,   32'd524288,
      32'd262144,    32'd131072,    32'd65536,     32'd32768,
      32'd16384,     32'd8192,      32'd4096,      32'd2048,
      32'd1024,      32'd512,       32'd256,       32'd128
   };

   // Step angle rounded half up to the working fraction width.
   function automatic angle_type step_angle(input int idx);
      logic [32:0] sum;
      sum = {1'b0, ATAN_TABLE[idx]} + (33'd1 << (TABLE_DROP - 1));
      return ANGLE_WIDTH'(sum >> TABLE_DROP);
   endfunction

endpackage

`default_nettype wire

### src/cordic_arctangent_unit.sv
// Top level of the CORDIC arctangent unit: an unrolled vectoring pipeline.
// Depends on catan_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Arctangent of a signed tangent word (16 fraction bits) by vectoring CORDIC.
// Input: a word is taken at a rising edge where start is high and busy is
// low. busy is always low, so a new word may be offered in every cycle.
// Output: rsp_valid marks rsp_angle_radians for exactly one cycle; the
// receiver takes it at the edge ending that cycle and cannot hold it off.
// Pipeline: a word taken at a rising edge passes through one input register,
// one register per CORDIC step and one saturating output register before it
// reaches the result ports.
// Throughput: one word per cycle; each step is one shift-add pair on the
// 36-bit vector plus one add on the angle, which sets the cycle.
// Reset clears every valid bit, so words in flight are dropped and no
// result appears until a new word is taken.
module cordic_arctangent_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output      logic                                busy,
   input  wire logic signed [catan_pkg::IN_WIDTH-1:0]  req_tangent_value,
   output      logic                                rsp_valid,
   output      logic signed [catan_pkg::OUT_WIDTH-1:0] rsp_angle_radians
);
   import catan_pkg::*;

   localparam int LATENCY = STAGES + 2;

   // Stage k holds the vector and angle before step k; angle_ff[STAGES] is final.
   xy_type    x_ff     [0:STAGES-1];
   xy_type    y_ff     [0:STAGES-1];
   angle_type angle_ff [0:STAGES];
   logic      valid_ff [0:STAGES];

   logic       out_valid_ff;
   result_type out_angle_ff;
   result_type out_angle_in;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else begin
         valid_ff[0] <= start & ~busy;
      end
      x_ff[0]     <= XY_WIDTH'(1) <<< FRACTION_BITS;
      y_ff[0]     <= XY_WIDTH'(req_tangent_value);
      angle_ff[0] <= '0;
   end

   for (genvar i = 0; i < STAGES; i++) begin : g_step
      xy_type    x_in;
      xy_type    y_in;
      angle_type angle_in;

      always_comb begin
         if (y_ff[i] < 0) begin
            x_in     = x_ff[i] - (y_ff[i] >>> i);
            y_in     = y_ff[i] + (x_ff[i] >>> i);
            angle_in = angle_ff[i] - step_angle(i);
         end else begin
            x_in     = x_ff[i] + (y_ff[i] >>> i);
            y_in     = y_ff[i] - (x_ff[i] >>> i);
            angle_in = angle_ff[i] + step_angle(i);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i+1] <= 1'b0;
         end else begin
            valid_ff[i+1] <= valid_ff[i];
         end
         angle_ff[i+1] <= angle_in;
      end

      // The last step only needs its angle.
      if (i < STAGES - 1) begin : g_vec
         always_ff @(posedge clock) begin
            x_ff[i+1] <= x_in;
            y_ff[i+1] <= y_in;
         end
      end
   end

   always_comb begin
      if (angle_ff[STAGES] > angle_type'(OUT_MAX)) begin
         out_angle_in = result_type'(OUT_MAX);
      end else if (angle_ff[STAGES] < angle_type'(OUT_MIN)) begin
         out_angle_in = result_type'(OUT_MIN);
      end else begin
         out_angle_in = angle_ff[STAGES][OUT_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= valid_ff[STAGES];
      end
      out_angle_ff <= out_angle_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_angle_radians = out_angle_ff;

   // Every accepted word comes out on rsp_valid.
   a_word_emerges: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("accepted word did not produce a result");

   // No result appears without a matching accepted word.
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("result without a matching accepted word");

   // A fractional-bit input never reaches saturation at the default format.
   a_sat_range: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[STAGES] && FRACTION_BITS <= 16) |=>
         (rsp_angle_radians != result_type'(OUT_MAX) &&
          rsp_angle_radians != result_type'(OUT_MIN)))
      else $error("angle saturated at the default fraction width");

endmodule

`default_nettype wire
